[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the dirty page bitmap RTL.
// Each use expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

// pre in one cycle implies post in the next
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[src/dpbl_pkg.sv]
// ---------------------------------------------------------------------------
// dpbl_pkg
// Types and constants of the dirty page bitmap log.
// ---------------------------------------------------------------------------
package dpbl_pkg;

	localparam int BASE_W    = 52;
	localparam int COUNT_W   = 16;
	localparam int WORD_W    = 64;
	localparam int BIT_W     = 6;
	localparam int CFG_IDX_W = 2;

	// request modes
	localparam logic [1:0] MODE_MARK  = 2'd0;
	localparam logic [1:0] MODE_RANGE = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_RSVD  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_PAGE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGES     = 2'd1;

	// result status codes
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] gpa;
		logic [63:0] dirty_length;
	} dpbl_in_t;

	typedef struct packed {
		logic status;
		logic is_set;
	} dpbl_out_t;

	// what the bitmap sequencer has to do for one request
	typedef enum logic [1:0] {
		OP_NONE,
		OP_MARK,
		OP_QUERY
	} dpbl_op_t;

	typedef struct packed {
		dpbl_op_t op;
		logic     status;
	} dpbl_cmd_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_S1,
		FR_S2,
		FR_CMD
	} front_state_t;

	typedef enum logic [1:0] {
		WK_IDLE,
		WK_RD,
		WK_MOD,
		WK_DONE
	} walk_state_t;

endpackage

[src/dpbl_bitmap_ram.sv]
// ---------------------------------------------------------------------------
// dpbl_bitmap_ram
// Bitmap word memory, one write and one registered read port, with a
// clearing sweep after reset that zeroes one word per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dpbl_bitmap_ram #(
	parameter int WORDS = 512,
	parameter int WW    = 9
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [WW-1:0]                  rd_addr,
	output logic [dpbl_pkg::WORD_W-1:0]    rd_data,
	input  logic                           wr_en,
	input  logic [WW-1:0]                  wr_addr,
	input  logic [dpbl_pkg::WORD_W-1:0]    wr_data,
	output logic                           clearing
);
	import dpbl_pkg::*;

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] rd_data_q;
	logic              clr_busy_q;
	logic [WW-1:0]     clr_addr_q;
	logic              we_c;
	logic [WW-1:0]     wa_c;
	logic [WORD_W-1:0] wd_c;

	// clear sweep owns the write port until it ends
	always_comb begin
		we_c = clr_busy_q || wr_en;
		wa_c = clr_busy_q ? clr_addr_q : wr_addr;
		wd_c = clr_busy_q ? '0 : wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + WW'(1);
			if (clr_addr_q == WW'(WORDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// storage and read register
	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[wa_c] <= wd_c;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clr_busy_q;

	`ASSERT_NEVER(a_no_user_write_in_clear, clr_busy_q && wr_en, "bitmap write lost to clear sweep")

endmodule

[src/dpbl_front.sv]
// ---------------------------------------------------------------------------
// dpbl_front
// Configuration registers, window check and two-stage argument check.
// Turns one request into a bitmap command with a bit index range.
// ---------------------------------------------------------------------------
module dpbl_front #(
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12,
	parameter int IW         = 15
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  dpbl_pkg::dpbl_in_t                  in_data,
	input  logic                                clearing,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dpbl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [63:0]                         cfg_data,
	output logic                                cmd_valid,
	input  logic                                cmd_ready,
	output dpbl_pkg::dpbl_cmd_t                 cmd,
	output logic [IW-1:0]                       cmd_start,
	output logic [IW-1:0]                       cmd_end
);
	import dpbl_pkg::*;

	localparam int PW = 64 - PAGE_SHIFT;
	localparam int VW = (PW > BASE_W) ? PW : BASE_W;

	front_state_t state_q, state_d;

	logic [BASE_W-1:0]  base_q;
	logic [COUNT_W-1:0] pages_q;

	// derived window
	logic [VW:0]        win_end_c;
	logic [COUNT_W-1:0] pages_m1_c;
	logic               win_ok_c;
	logic               win_ok_q;
	logic [PW-1:0]      tlast_q;
	logic [IW-1:0]      last_rel_q;

	// stage 1
	dpbl_in_t      in_s1;
	logic [PW-1:0] page_c;
	logic          aligned_c;
	logic          in_lo_c;
	logic          in_hi_c;
	logic [IW-1:0] idx_c;
	logic          len_ok_c;
	logic [64:0]   sum_c;
	logic          ok_c;

	// stage 2
	logic [1:0]    mode_s2;
	logic          status_s2;
	logic          in_lo_s2;
	logic          in_hi_s2;
	logic [IW-1:0] idx_s2;
	logic [PW-1:0] dlast_s2;
	logic          dl_ge_base_c;
	logic          dl_le_last_c;
	logic [IW-1:0] dl_rel_c;
	dpbl_cmd_t     cmd_c;
	logic [IW-1:0] start_c;
	logic [IW-1:0] end_c;

	// command hold
	dpbl_cmd_t     cmd_s3;
	logic [IW-1:0] start_s3;
	logic [IW-1:0] end_s3;

	logic in_acc;
	logic cfg_wr;

	assign in_acc = in_valid && !in_stall;
	assign cfg_wr = cfg_valid && cfg_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			pages_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_BASE_PAGE: base_q  <= cfg_data[BASE_W-1:0];
				REG_PAGES:     pages_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// window validity and last page, refreshed every cycle
	assign win_end_c  = (VW+1)'(base_q) + (VW+1)'(pages_q) - (VW+1)'(1);
	assign pages_m1_c = pages_q - COUNT_W'(1);
	assign win_ok_c   = (pages_q != '0) && (32'(pages_q) <= 32'(MAX_PAGES))
		&& ((win_end_c >> PW) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_ok_q <= 1'b0;
		end else begin
			win_ok_q <= win_ok_c;
		end
	end

	always_ff @(posedge clk) begin
		tlast_q    <= win_end_c[PW-1:0];
		last_rel_q <= IW'(pages_m1_c);
	end

	// stage 1: alignment, window membership, range wrap
	assign page_c    = in_s1.gpa[63:PAGE_SHIFT];
	assign aligned_c = in_s1.gpa[PAGE_SHIFT-1:0] == '0;
	assign in_lo_c   = VW'(page_c) >= VW'(base_q);
	assign in_hi_c   = page_c <= tlast_q;
	assign idx_c     = IW'(page_c - PW'(base_q));
	assign sum_c     = {1'b0, in_s1.gpa} + {1'b0, in_s1.dirty_length} - 65'd1;
	assign len_ok_c  = (in_s1.dirty_length != '0)
		&& (in_s1.dirty_length[PAGE_SHIFT-1:0] == '0) && !sum_c[64];

	always_comb begin
		ok_c = 1'b0;
		if ((in_s1.mode != MODE_RSVD) && win_ok_q && aligned_c) begin
			ok_c = (in_s1.mode == MODE_RANGE) ? len_ok_c : (in_lo_c && in_hi_c);
		end
	end

	// stage 2: pick the command and clip a range to the window
	assign dl_ge_base_c = VW'(dlast_s2) >= VW'(base_q);
	assign dl_le_last_c = dlast_s2 <= tlast_q;
	assign dl_rel_c     = IW'(dlast_s2 - PW'(base_q));

	always_comb begin
		cmd_c.op     = OP_NONE;
		cmd_c.status = status_s2;
		start_c      = idx_s2;
		end_c        = idx_s2;
		if (status_s2 == STATUS_OK) begin
			case (mode_s2)
				MODE_MARK:  cmd_c.op = OP_MARK;
				MODE_QUERY: cmd_c.op = OP_QUERY;
				MODE_RANGE: begin
					start_c = in_lo_s2 ? idx_s2 : '0;
					end_c   = dl_le_last_c ? dl_rel_c : last_rel_q;
					if (in_hi_s2 && dl_ge_base_c) begin
						cmd_c.op = OP_MARK;
					end
				end
				default: cmd_c.op = OP_NONE;
			endcase
		end
	end

	// pipeline registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_s1 <= in_data;
		end
		if (state_q == FR_S1) begin
			mode_s2   <= in_s1.mode;
			status_s2 <= ok_c ? STATUS_OK : STATUS_INVALID;
			in_lo_s2  <= in_lo_c;
			in_hi_s2  <= in_hi_c;
			idx_s2    <= idx_c;
			dlast_s2  <= sum_c[63:PAGE_SHIFT];
		end
		if (state_q == FR_S2) begin
			cmd_s3   <= cmd_c;
			start_s3 <= start_c;
			end_s3   <= end_c;
		end
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE: if (in_acc) begin
				state_d = FR_S1;
			end
			FR_S1:   state_d = FR_S2;
			FR_S2:   state_d = FR_CMD;
			FR_CMD:  if (cmd_ready) begin
				state_d = FR_IDLE;
			end
			default: state_d = FR_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_stall  = (state_q != FR_IDLE) || clearing;
		cfg_ready = (state_q == FR_IDLE) && !in_valid;
		cmd_valid = state_q == FR_CMD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd       = cmd_s3;
	assign cmd_start = start_s3;
	assign cmd_end   = end_s3;

endmodule

[src/dpbl_walk.sv]
// ---------------------------------------------------------------------------
// dpbl_walk
// Bitmap sequencer: read-modify-write over the words of a bit range, or a
// single read for a query, then loads the result register; OP_NONE skips the memory.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dpbl_walk #(
	parameter int IW = 15,
	parameter int WW = 9
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  dpbl_pkg::dpbl_cmd_t            cmd,
	input  logic [IW-1:0]                  cmd_start,
	input  logic [IW-1:0]                  cmd_end,
	output logic                           rd_en,
	output logic [WW-1:0]                  rd_addr,
	input  logic [dpbl_pkg::WORD_W-1:0]    rd_data,
	output logic                           wr_en,
	output logic [WW-1:0]                  wr_addr,
	output logic [dpbl_pkg::WORD_W-1:0]    wr_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output dpbl_pkg::dpbl_out_t            out_data
);
	import dpbl_pkg::*;

	walk_state_t state_q, state_d;

	dpbl_op_t      op_q;
	logic          status_q;
	logic          is_set_q;
	logic [IW-1:0] start_q;
	logic [IW-1:0] end_q;
	logic [WW-1:0] wptr_q;
	logic          out_valid_q;
	dpbl_out_t     out_q;

	logic [WW-1:0]     sword;
	logic [WW-1:0]     eword;
	logic [BIT_W-1:0]  lo_c;
	logic [BIT_W-1:0]  hi_c;
	logic [WORD_W-1:0] mask_c;
	logic              out_free;
	logic              take_cmd;

	assign sword    = WW'(start_q >> BIT_W);
	assign eword    = WW'(end_q >> BIT_W);
	assign out_free = !out_valid_q || !out_stall;
	assign take_cmd = (state_q == WK_IDLE) && cmd_valid;

	// bit mask of the range within the current word
	always_comb begin
		lo_c   = (wptr_q == sword) ? start_q[BIT_W-1:0] : '0;
		hi_c   = (wptr_q == eword) ? end_q[BIT_W-1:0] : '1;
		mask_c = ({WORD_W{1'b1}} << lo_c) & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_c));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			WK_IDLE: if (cmd_valid) begin
				state_d = (cmd.op == OP_NONE) ? WK_DONE : WK_RD;
			end
			WK_RD:   state_d = WK_MOD;
			WK_MOD:  state_d = ((op_q == OP_QUERY) || (wptr_q == eword)) ? WK_DONE : WK_RD;
			WK_DONE: if (out_free) begin
				state_d = WK_IDLE;
			end
			default: state_d = WK_IDLE;
		endcase
	end

	// memory and handshake outputs
	always_comb begin
		cmd_ready = state_q == WK_IDLE;
		rd_en     = state_q == WK_RD;
		rd_addr   = wptr_q;
		wr_en     = (state_q == WK_MOD) && (op_q == OP_MARK);
		wr_addr   = wptr_q;
		wr_data   = rd_data | mask_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= WK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == WK_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command latch, word pointer, query bit, result register
	always_ff @(posedge clk) begin
		if (take_cmd) begin
			op_q     <= cmd.op;
			status_q <= cmd.status;
			start_q  <= cmd_start;
			end_q    <= cmd_end;
			wptr_q   <= WW'(cmd_start >> BIT_W);
			is_set_q <= 1'b0;
		end
		if (state_q == WK_MOD) begin
			wptr_q <= wptr_q + WW'(1);
			if (op_q == OP_QUERY) begin
				is_set_q <= rd_data[start_q[BIT_W-1:0]];
			end
		end
		if ((state_q == WK_DONE) && out_free) begin
			out_q.status <= status_q;
			out_q.is_set <= is_set_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_NEXT(a_read_then_modify, rd_en, state_q == WK_MOD, "read not followed by modify")
	`ASSERT_NEVER(a_wptr_past_end, (state_q == WK_MOD) && (wptr_q > eword), "word pointer past range")

endmodule

[src/dirty_page_bitmap_log.sv]
// Flow: the front checks a request in stage 1 and 2 and holds the command until the
// sequencer takes it. A rejected or window-missing request skips the bitmap; a mark
// reads and writes back each word it covers, a query reads one word. The front may
// check the next request while the sequencer works on the last; results wait out
// receiver stalls. Reset: control registers clear at once; a sweep then zeroes the
// (MAX_PAGES+63)/64 bitmap words (512 by default) while input is stalled.
// ---------------------------------------------------------------------------
// dirty_page_bitmap_log
// Dirty bit per guest page over a configured window: mark, range mark, query.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dirty_page_bitmap_log #(
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  dpbl_pkg::dpbl_in_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output dpbl_pkg::dpbl_out_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dpbl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                        cfg_data
);
	import dpbl_pkg::*;

	localparam int WORDS = (MAX_PAGES + 63) / 64;
	localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int IW    = $clog2(MAX_PAGES);

	logic              clearing;
	logic              cmd_valid;
	logic              cmd_ready;
	dpbl_cmd_t         cmd;
	logic [IW-1:0]     cmd_start;
	logic [IW-1:0]     cmd_end;
	logic              rd_en;
	logic [WW-1:0]     rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [WW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;

	dpbl_front #(
		.MAX_PAGES (MAX_PAGES),
		.PAGE_SHIFT(PAGE_SHIFT),
		.IW        (IW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.clearing (clearing),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.cmd_start(cmd_start),
		.cmd_end  (cmd_end)
	);

	dpbl_walk #(
		.IW(IW),
		.WW(WW)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.cmd_start(cmd_start),
		.cmd_end  (cmd_end),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	dpbl_bitmap_ram #(
		.WORDS(WORDS),
		.WW   (WW)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.clearing(clearing)
	);

	`ASSERT_NEVER(a_no_accept_in_clear, in_valid && !in_stall && clearing, "accept in clear")

endmodule

[dv/dirty_page_bitmap_log_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dirty_page_bitmap_log_tb
// Self-checking bench for the dirty page bitmap log. A shadow copy of the
// bitmap and the window registers predicts status and is_set for every
// accepted request; results are checked in order as they leave the block.
// Windows change between phases while the block is idle; sender gaps and
// receiver stalls vary per phase.
// ---------------------------------------------------------------------------
module dirty_page_bitmap_log_tb;
	import dpbl_pkg::*;

	localparam int TRACK_LIMIT  = 32768;
	localparam int PAGE_BITS    = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 12;
	localparam int QUIET_LIMIT  = 20000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [63:0] TOP_PAGE_GPA = 64'hFFFF_FFFF_FFFF_F000;

	// shadow of the dirty bitmap and window registers, plus the results in flight
	class bitmap_mirror;
		bit [63:0]  dirty_words [TRACK_LIMIT/64];
		bit [51:0]  base_page;
		bit [15:0]  page_count;
		dpbl_out_t  pending [$];
		int         errors;
		int         results_seen;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
			if (idx == REG_BASE_PAGE)
				base_page = val[51:0];
			else if (idx == REG_PAGES)
				page_count = val[15:0];
		endfunction

		function void mark_page(logic [63:0] pidx);
			dirty_words[pidx[14:6]][pidx[5:0]] = 1'b1;
		endfunction

		// work out the result of one request and update the bitmap
		function void note_request(dpbl_in_t req);
			logic [63:0] base64, last_page, page, first, stop, p;
			dpbl_out_t   res;
			bit          win_ok;
			base64 = {12'h0, base_page};
			res.status = STATUS_INVALID;
			res.is_set = 1'b0;
			last_page = base64 + 64'(page_count) - 64'd1;
			win_ok = page_count != 0 && page_count <= TRACK_LIMIT
				&& last_page < (64'd1 << (64 - PAGE_BITS));
			if (req.mode == MODE_RSVD || !win_ok || req.gpa[PAGE_BITS-1:0] != 0) begin
				res.status = STATUS_INVALID;
			end else if (req.mode == MODE_MARK || req.mode == MODE_QUERY) begin
				page = req.gpa >> PAGE_BITS;
				if (page >= base64 && page <= last_page) begin
					res.status = STATUS_OK;
					if (req.mode == MODE_MARK)
						mark_page(page - base64);
					else begin
						p = page - base64;
						res.is_set = dirty_words[p[14:6]][p[5:0]];
					end
				end
			end else begin
				// range: clip to the window, a miss is still ok
				if (req.dirty_length != 0 && req.dirty_length[PAGE_BITS-1:0] == 0
						&& req.gpa <= ~(req.dirty_length - 64'd1)) begin
					res.status = STATUS_OK;
					page = req.gpa >> PAGE_BITS;
					stop = page + (req.dirty_length >> PAGE_BITS) - 64'd1;
					first = (page > base64) ? page : base64;
					if (last_page < stop)
						stop = last_page;
					for (p = first; p <= stop; p++)
						mark_page(p - base64);
				end
			end
			pending.push_back(res);
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(dpbl_out_t got);
			dpbl_out_t want;
			results_seen++;
			if (pending.size() == 0) begin
				report($sformatf("result %0d (status %b is_set %b) with no request outstanding",
					results_seen, got.status, got.is_set));
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status)
				report($sformatf("result %0d: status %b, expected %b",
					results_seen, got.status, want.status));
			if (got.is_set !== want.is_set)
				report($sformatf("result %0d: is_set %b, expected %b",
					results_seen, got.is_set, want.is_set));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	dpbl_in_t               in_data;
	logic                   out_valid;
	logic                   out_stall;
	dpbl_out_t              out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [63:0]            cfg_data;

	bitmap_mirror mirror;

	int          gap_pct;
	int          stall_pct;
	bit          hold_tog;
	bit          hold_seen;
	int          hold_left;
	int          quiet;
	bit          progress;
	logic [51:0] win_base;
	logic [15:0] win_pages;
	logic [63:0] marked_pages [$];

	dirty_page_bitmap_log #(
		.MAX_PAGES  (TRACK_LIMIT),
		.PAGE_SHIFT (PAGE_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// accepted words go to the shadow; watchdog on cycles with no progress
	always @(posedge clk) begin
		if (arst_n) begin
			progress = 1'b0;
			if (cfg_valid && cfg_ready) begin
				mirror.set_reg(cfg_index, cfg_data);
				progress = 1'b1;
			end
			if (in_valid && !in_stall) begin
				mirror.note_request(in_data);
				progress = 1'b1;
			end
			if (out_valid && !out_stall) begin
				mirror.check_result(out_data);
				progress = 1'b1;
			end
			quiet = progress ? 0 : quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen = hold_tog;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall = 1'b1;
		end else
			out_stall = ($urandom_range(99) < stall_pct);
	end

	// offer one request word, with random gaps ahead of it
	task automatic push_item(dpbl_in_t item);
		while ($urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results(int settle);
		while (mirror.pending.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// new window while idle; unused upper bits of the data carry junk
	task automatic set_window(logic [51:0] base, logic [15:0] pages, bit spare = 1'b0);
		in_valid = 1'b0;
		drain_results(SETTLE);
		cfg_write(REG_BASE_PAGE, {12'($urandom), base});
		cfg_write(REG_PAGES, {$urandom, 16'($urandom), pages});
		if (spare)
			cfg_write(REG_SPARE, {$urandom, $urandom});
		cfg_valid = 1'b0;
		win_base  = base;
		win_pages = pages;
	endtask

	function automatic logic [51:0] rand_base();
		logic [51:0] b;
		b = 52'({$urandom, $urandom});
		b[51] = 1'b0;
		return b;
	endfunction

	// mostly well-formed requests aimed at and around the window, some noise
	function automatic dpbl_in_t make_item(bit allow_huge);
		dpbl_in_t    it;
		int unsigned span, pick;
		logic [63:0] page, npages;
		span = (win_pages == 0) ? 1 : (win_pages > TRACK_LIMIT ? TRACK_LIMIT : win_pages);
		it.mode = 2'($urandom_range(3));
		it.gpa = {$urandom, $urandom};
		it.dirty_length = {$urandom, $urandom};
		if ($urandom_range(99) < 8)
			return it;
		pick = $urandom_range(99);
		if (pick < 75)
			page = {12'h0, win_base} + 64'($urandom_range(span - 1));
		else if (pick < 85)
			page = {12'h0, win_base} - 64'd1;
		else if (pick < 95)
			page = {12'h0, win_base} + 64'(span);
		else
			page = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 40)
			it.mode = MODE_MARK;
		else if (pick < 65)
			it.mode = MODE_RANGE;
		else if (pick < 97)
			it.mode = MODE_QUERY;
		else
			it.mode = MODE_RSVD;
		if (it.mode == MODE_QUERY && marked_pages.size() != 0 && $urandom_range(1))
			page = marked_pages[$urandom_range(marked_pages.size() - 1)];
		if (it.mode == MODE_RANGE)
			page = page - 64'($urandom_range(8));
		page[63:52] = '0;
		it.gpa = page << PAGE_BITS;
		if (it.mode == MODE_MARK) begin
			marked_pages.push_back(page);
			if (marked_pages.size() > 64)
				void'(marked_pages.pop_front());
		end
		if (it.mode == MODE_RANGE) begin
			npages = 64'(1 + $urandom_range(63));
			if (allow_huge && $urandom_range(19) == 0)
				npages = 64'(span + $urandom_range(300));
			it.dirty_length = npages << PAGE_BITS;
			pick = $urandom_range(99);
			if (pick < 3)
				it.dirty_length = '0;
			else if (pick < 6)
				it.dirty_length[PAGE_BITS-1:0] = 12'($urandom_range(4095, 1));
			else if (pick < 9) begin
				// runs past the top of the address space
				it.gpa = TOP_PAGE_GPA - (64'($urandom_range(4)) << PAGE_BITS);
				it.dirty_length = 64'(8 + $urandom_range(8)) << PAGE_BITS;
			end
		end
		if ($urandom_range(99) < 4)
			it.gpa[PAGE_BITS-1:0] = 12'($urandom_range(4095, 1));
		return it;
	endfunction

	task automatic send_random(int count, bit allow_huge);
		repeat (count) push_item(make_item(allow_huge));
	endtask

	task automatic set_idling(int gap, int stall);
		gap_pct   = gap;
		stall_pct = stall;
	endtask

	initial begin
		mirror    = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE_PAGE;
		cfg_data  = '0;
		gap_pct   = 0;
		stall_pct = 0;
		hold_tog  = 1'b0;
		win_base  = '0;
		win_pages = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: window still at reset, so nothing is valid
		push_item(dpbl_in_t'{MODE_MARK, 64'h0, 64'h0});
		push_item(dpbl_in_t'{MODE_RSVD, 64'h0, 64'h0});

		// full-size window at page zero
		set_window(52'h0, 16'(TRACK_LIMIT));
		push_item(dpbl_in_t'{MODE_MARK, 64'h0, 64'h0});
		push_item(dpbl_in_t'{MODE_QUERY, 64'h0, 64'h0});
		push_item(dpbl_in_t'{MODE_MARK, 64'(TRACK_LIMIT - 1) << PAGE_BITS, 64'h0});
		push_item(dpbl_in_t'{MODE_QUERY, 64'(TRACK_LIMIT) << PAGE_BITS, 64'h0});
		push_item(dpbl_in_t'{MODE_MARK, 64'h1, 64'h0});
		push_item(dpbl_in_t'{MODE_RANGE, 64'h0, 64'h0});
		push_item(dpbl_in_t'{MODE_RANGE, 64'h1000, 64'h1800});
		push_item(dpbl_in_t'{MODE_RANGE, TOP_PAGE_GPA, 64'h2000});
		push_item(dpbl_in_t'{MODE_RANGE, TOP_PAGE_GPA, 64'h1000});
		push_item(dpbl_in_t'{MODE_RANGE, 64'h10000, 64'h40000});
		push_item(dpbl_in_t'{MODE_QUERY, 64'd79 << PAGE_BITS, 64'h0});
		push_item(dpbl_in_t'{MODE_QUERY, 64'd80 << PAGE_BITS, 64'h0});
		push_item(dpbl_in_t'{MODE_QUERY, 64'h5000, {64{1'b1}}});
		push_item(dpbl_in_t'{MODE_RSVD, 64'h10000, 64'h1000});

		// small window: ranges clipped at one end and at both
		set_window(52'd100, 16'd50);
		push_item(dpbl_in_t'{MODE_RANGE, 64'd90 << PAGE_BITS, 64'd20 << PAGE_BITS});
		push_item(dpbl_in_t'{MODE_RANGE, 64'd90 << PAGE_BITS, 64'd100 << PAGE_BITS});
		push_item(dpbl_in_t'{MODE_QUERY, 64'd150 << PAGE_BITS, 64'h0});

		// single page at the very top of the address space
		set_window({52{1'b1}}, 16'd1);
		push_item(dpbl_in_t'{MODE_MARK, TOP_PAGE_GPA, 64'h0});
		push_item(dpbl_in_t'{MODE_QUERY, TOP_PAGE_GPA, 64'h0});
		push_item(dpbl_in_t'{MODE_RANGE, 64'h0, TOP_PAGE_GPA});

		// window running off the end, then one longer than the bitmap
		set_window({52{1'b1}}, 16'd2);
		push_item(dpbl_in_t'{MODE_QUERY, TOP_PAGE_GPA, 64'h0});
		set_window(52'd5, 16'd40000);
		push_item(dpbl_in_t'{MODE_MARK, 64'd5 << PAGE_BITS, 64'h0});

		// random phases
		set_window(rand_base(), 16'd64);
		set_idling(0, 0);
		send_random(125, 1'b0);

		set_window({52{1'b1}} - 52'(TRACK_LIMIT - 1), 16'(TRACK_LIMIT));
		set_idling(49, 0);
		send_random(125, 1'b0);

		// receiver holds off long enough for the block to back up
		set_window(rand_base(), 16'(1 + $urandom_range(TRACK_LIMIT - 1)));
		set_idling(0, 49);
		send_random(30, 1'b0);
		hold_tog = ~hold_tog;
		send_random(95, 1'b0);

		set_window(rand_base(), 16'd1);
		set_idling(6, 6);
		send_random(100, 1'b1);

		// sender waits for every result mid-phase
		set_window(rand_base(), 16'(1 + $urandom_range(199)), 1'b1);
		set_idling(0, 0);
		send_random(60, 1'b1);
		in_valid = 1'b0;
		drain_results(0);
		send_random(60, 1'b1);

		set_window(52'h0, 16'(TRACK_LIMIT));
		set_idling(49, 0);
		send_random(125, 1'b0);

		// invalid windows: empty, too long, past the address space
		set_window(rand_base(), 16'd0);
		set_idling(0, 49);
		send_random(30, 1'b0);
		set_window(rand_base(), 16'(TRACK_LIMIT + 1 + $urandom_range(32766)));
		send_random(30, 1'b0);
		set_window({52{1'b1}} - 52'd9, 16'd64);
		send_random(30, 1'b0);

		set_window(rand_base(), 16'd1000);
		set_idling(6, 6);
		send_random(125, 1'b1);

		// one range over the whole bitmap, then a few more
		set_window(52'h0, 16'(TRACK_LIMIT));
		set_idling(0, 0);
		push_item(dpbl_in_t'{MODE_RANGE, 64'h0, TOP_PAGE_GPA});
		send_random(20, 1'b0);

		in_valid = 1'b0;
		drain_results(SETTLE);
		if (mirror.errors == 0 && mirror.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/dpbl_pkg.sv
src/dpbl_bitmap_ram.sv
src/dpbl_front.sv
src/dpbl_walk.sv
src/dirty_page_bitmap_log.sv
dv/dirty_page_bitmap_log_tb.sv
